// ===== hdl/dmrp_pkg.sv =====
package dmrp_pkg;

    localparam int DMRP_POOL_SLOTS = 16;

    localparam logic [2:0] MODE_ACQUIRE = 3'd0;
    localparam logic [2:0] MODE_RELEASE = 3'd1;
    localparam logic [2:0] MODE_TICK    = 3'd2;
    localparam logic [2:0] MODE_SWEEP   = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    localparam logic [2:0] ST_REUSED    = 3'd0;
    localparam logic [2:0] ST_CREATED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    localparam logic REG_IDLE_THRESHOLD = 1'b0;
    localparam logic REG_MAX_DROPS      = 1'b1;

    localparam logic [15:0] IDLE_THRESHOLD_RST = 16'd3;
    localparam logic [4:0]  MAX_DROPS_RST      = 5'd1;
    localparam logic [15:0] IDLE_MAX           = 16'hFFFF;

    typedef struct packed {
        logic [14:0] width;
        logic [14:0] height;
        logic [7:0]  format;
        logic        is_depth;
    } t_desc;

    typedef struct packed {
        logic desc_en;
        logic idle_en;
    } t_slot_we;

endpackage

// ===== hdl/dmrp_slot_store.sv =====
module dmrp_slot_store import dmrp_pkg::*; #(
    parameter int POOL_SLOTS = DMRP_POOL_SLOTS,
    parameter int SLOT_W     = $clog2(POOL_SLOTS)
) (
    input  logic              i_clk,
    input  t_slot_we          i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  t_desc             i_wdesc,
    input  logic [15:0]       i_widle,
    input  logic [SLOT_W-1:0] i_raddr,
    output t_desc             o_rdesc,
    output logic [15:0]       o_ridle
);

    t_desc       mem_desc [POOL_SLOTS];
    logic [15:0] mem_idle [POOL_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we.desc_en) begin
            mem_desc[i_waddr] <= i_wdesc;
        end
        if (i_we.idle_en) begin
            mem_idle[i_waddr] <= i_widle;
        end
        o_rdesc <= mem_desc[i_raddr];
        o_ridle <= mem_idle[i_raddr];
    end

endmodule

// ===== hdl/dmrp_order_store.sv =====
module dmrp_order_store import dmrp_pkg::*; #(
    parameter int POOL_SLOTS = DMRP_POOL_SLOTS,
    parameter int SLOT_W     = $clog2(POOL_SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  logic [SLOT_W-1:0] i_wdata,
    input  logic [SLOT_W-1:0] i_raddr,
    output logic [SLOT_W-1:0] o_rdata
);

    logic [SLOT_W-1:0] mem [POOL_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== hdl/descriptor_matched_resource_pool_top.sv =====
// resource pool allocator: a word is taken when start is high and busy is low,
// and exactly one result word follows, shown for one cycle with o_done high;
// the receiver cannot stall, so results must be taken when o_done pulses.
// release, clear and unknown modes go straight to the final step; acquire,
// tick and sweep first walk the free list, visiting each free slot with an order
// memory read, then a descriptor memory read, then an evaluate step. the user
// must write configuration over the apb port only while busy is low; the block
// does not enforce this. slot valid and in-use bits are flip-flops cleared by reset.
module descriptor_matched_resource_pool_top import dmrp_pkg::*; #(
    parameter int POOL_SLOTS = DMRP_POOL_SLOTS,
    parameter int SLOT_W     = $clog2(POOL_SLOTS),
    parameter int CNT_W      = $clog2(POOL_SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_mode,
    input  logic [14:0]       i_req_width,
    input  logic [14:0]       i_req_height,
    input  logic [7:0]        i_req_format,
    input  logic              i_req_is_depth,
    input  logic [SLOT_W-1:0] i_release_handle,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_handle,
    output logic [2:0]        o_status,
    output logic [4:0]        o_dropped_count,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ORD  = 5'b00010,
        S_SLOT = 5'b00100,
        S_EVAL = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [15:0] r_idle_threshold;
    logic [4:0]  r_max_drops;

    // latched request word
    logic [2:0]        r_mode;
    t_desc             r_req;
    logic [SLOT_W-1:0] r_rel;

    // slot flags in flip-flops
    logic [POOL_SLOTS-1:0] r_valid, r_in_use;
    logic [CNT_W-1:0]      r_free_count;

    // walk state
    logic [CNT_W-1:0]  r_k, r_wr;
    logic [SLOT_W-1:0] r_slot;
    logic              r_found;
    logic [SLOT_W-1:0] r_found_slot;
    logic [4:0]        r_dropped;

    // result registers
    logic              r_done;
    logic [SLOT_W-1:0] r_handle;
    logic [2:0]        r_status;
    logic [4:0]        r_drop_out;

    // memory ports
    t_slot_we          slot_we;
    logic [SLOT_W-1:0] slot_waddr, slot_raddr;
    t_desc             slot_wdesc, slot_rdesc;
    logic [15:0]       slot_widle, slot_ridle;
    logic              ord_we;
    logic [SLOT_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;

    dmrp_slot_store #(.POOL_SLOTS(POOL_SLOTS), .SLOT_W(SLOT_W)) u_slot (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdesc(slot_wdesc),
        .i_widle(slot_widle),
        .i_raddr(slot_raddr),
        .o_rdesc(slot_rdesc),
        .o_ridle(slot_ridle)
    );

    dmrp_order_store #(.POOL_SLOTS(POOL_SLOTS), .SLOT_W(SLOT_W)) u_order (
        .i_clk  (i_clk),
        .i_we   (ord_we),
        .i_waddr(ord_waddr),
        .i_wdata(ord_wdata),
        .i_raddr(ord_raddr),
        .o_rdata(ord_rdata)
    );

    // apb register port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_IDLE_THRESHOLD: prdata = {16'd0, r_idle_threshold};
            REG_MAX_DROPS:      prdata = {27'd0, r_max_drops};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_threshold <= IDLE_THRESHOLD_RST;
            r_max_drops      <= MAX_DROPS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IDLE_THRESHOLD: r_idle_threshold <= pwdata[15:0];
                REG_MAX_DROPS:      r_max_drops      <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // lowest unused slot for creation
    logic              have_unused;
    logic [SLOT_W-1:0] unused_slot;
    always_comb begin
        have_unused = 1'b0;
        unused_slot = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                have_unused = 1'b1;
                unused_slot = SLOT_W'(i);
            end
        end
    end

    // per-element decision while walking the free list
    logic desc_match, is_old, drop_here;
    assign desc_match = (slot_rdesc == r_req);
    assign is_old     = (slot_ridle >= r_idle_threshold);
    always_comb begin
        case (r_mode)
            MODE_ACQUIRE: drop_here = desc_match && !r_found;
            MODE_SWEEP:   drop_here = is_old && (r_dropped < r_max_drops);
            default:      drop_here = 1'b0;
        endcase
    end

    // release legality
    logic rel_ok;
    assign rel_ok = ({{(32-SLOT_W){1'b0}}, r_rel} < 32'(POOL_SLOTS))
                    && r_valid[r_rel] && r_in_use[r_rel]
                    && (r_free_count < CNT_W'(POOL_SLOTS));

    logic walk_mode, last_elem;
    assign walk_mode = (i_mode == MODE_ACQUIRE) || (i_mode == MODE_TICK)
                       || (i_mode == MODE_SWEEP);
    assign last_elem = (r_k + CNT_W'(1)) == r_free_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (walk_mode && r_free_count != '0) ? S_ORD : S_FIN;
                end
            end
            S_ORD:  n_state = S_SLOT;
            S_SLOT: n_state = S_EVAL;
            S_EVAL: n_state = last_elem ? S_FIN : S_ORD;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port steering
    always_comb begin
        slot_we    = '0;
        slot_waddr = r_slot;
        slot_wdesc = r_req;
        slot_widle = '0;
        slot_raddr = ord_rdata;
        ord_we     = 1'b0;
        ord_waddr  = r_wr[SLOT_W-1:0];
        ord_wdata  = r_slot;
        ord_raddr  = r_k[SLOT_W-1:0];
        if (r_state == S_EVAL) begin
            // kept entries are compacted toward the head
            ord_we = !drop_here;
            if (r_mode == MODE_TICK) begin
                slot_we.idle_en = 1'b1;
                slot_widle = (slot_ridle != IDLE_MAX) ? slot_ridle + 16'd1 : slot_ridle;
            end
        end else if (r_state == S_FIN) begin
            if (r_mode == MODE_RELEASE && rel_ok) begin
                ord_we          = 1'b1;
                ord_waddr       = r_free_count[SLOT_W-1:0];
                ord_wdata       = r_rel;
                slot_we.idle_en = 1'b1;
                slot_waddr      = r_rel;
            end else if (r_mode == MODE_ACQUIRE && !r_found && have_unused) begin
                slot_we.desc_en = 1'b1;
                slot_we.idle_en = 1'b1;
                slot_waddr      = unused_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_in_use     <= '0;
            r_free_count <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode    <= i_mode;
                        r_req     <= '{i_req_width, i_req_height, i_req_format,
                                       i_req_is_depth};
                        r_rel     <= i_release_handle;
                        r_k       <= '0;
                        r_wr      <= '0;
                        r_found   <= 1'b0;
                        r_dropped <= '0;
                    end
                end
                S_ORD: ;
                S_SLOT: r_slot <= ord_rdata;
                S_EVAL: begin
                    r_k <= r_k + CNT_W'(1);
                    if (!drop_here) begin
                        r_wr <= r_wr + CNT_W'(1);
                    end else if (r_mode == MODE_ACQUIRE) begin
                        r_found          <= 1'b1;
                        r_found_slot     <= r_slot;
                        r_in_use[r_slot] <= 1'b1;
                    end else begin
                        r_dropped        <= r_dropped + 5'd1;
                        r_valid[r_slot]  <= 1'b0;
                        r_in_use[r_slot] <= 1'b0;
                    end
                    if (last_elem) begin
                        r_free_count <= drop_here ? r_wr : r_wr + CNT_W'(1);
                    end
                end
                S_FIN: begin
                    r_done     <= 1'b1;
                    r_handle   <= '0;
                    r_status   <= ST_DONE;
                    r_drop_out <= '0;
                    case (r_mode)
                        MODE_ACQUIRE: begin
                            if (r_found) begin
                                r_handle <= r_found_slot;
                                r_status <= ST_REUSED;
                            end else if (have_unused) begin
                                r_handle <= unused_slot;
                                r_status <= ST_CREATED;
                                r_valid[unused_slot]  <= 1'b1;
                                r_in_use[unused_slot] <= 1'b1;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                        MODE_RELEASE: begin
                            if (rel_ok) begin
                                r_in_use[r_rel] <= 1'b0;
                                r_free_count    <= r_free_count + CNT_W'(1);
                            end else begin
                                r_status <= ST_NOT_FOUND;
                            end
                        end
                        MODE_TICK: ;
                        MODE_SWEEP: r_drop_out <= r_dropped;
                        MODE_CLEAR: begin
                            r_valid      <= '0;
                            r_in_use     <= '0;
                            r_free_count <= '0;
                        end
                        default: r_status <= ST_NOT_FOUND;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_handle        = r_handle;
    assign o_status        = r_status;
    assign o_dropped_count = r_drop_out;

    // an accepted word always starts a busy interval
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // a result only follows the final sequencer step
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FIN))
        else $error("result without final step");

    // free list never grows past the pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= CNT_W'(POOL_SLOTS))
        else $error("free count over pool size");

    // a granted slot is valid and in use
    a_grant_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_CREATED || o_status == ST_REUSED))
        |-> (r_valid[o_handle] && r_in_use[o_handle]))
        else $error("granted slot not in use");

endmodule

// ===== tb/tb.sv =====
module tb;
    import dmrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = DMRP_POOL_SLOTS;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // command port
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_mode = MODE_CLEAR;
    logic [14:0] i_req_width = '0;
    logic [14:0] i_req_height = '0;
    logic [7:0]  i_req_format = '0;
    logic        i_req_is_depth = 1'b0;
    logic [3:0]  i_release_handle = '0;
    logic        o_done;
    logic [3:0]  o_handle;
    logic [2:0]  o_status;
    logic [4:0]  o_dropped_count;

    // apb port
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    descriptor_matched_resource_pool_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_req_width(i_req_width), .i_req_height(i_req_height),
        .i_req_format(i_req_format), .i_req_is_depth(i_req_is_depth),
        .i_release_handle(i_release_handle), .o_done(o_done), .o_handle(o_handle),
        .o_status(o_status), .o_dropped_count(o_dropped_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // one expected result word
    typedef struct packed {
        logic [3:0] handle;
        logic [2:0] status;
        logic [4:0] dropped;
    } pool_answer_t;

    // predictor copy of the pool
    logic [15:0] thresh_q;
    logic [4:0]  drop_limit_q;
    logic        p_valid   [NSLOT];
    logic        p_in_use  [NSLOT];
    t_desc       p_desc    [NSLOT];
    logic [15:0] p_idle    [NSLOT];
    logic [3:0]  p_free_q  [$];

    pool_answer_t answers_pending [$];
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int n_reused = 0, n_created = 0, n_full = 0, n_drops = 0;
    int sender_idle_pct = 0;
    longint cycle_cnt = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
        errors++;
    endtask

    // next state and answer of the pool for one command word
    function automatic pool_answer_t pool_predict(input logic [2:0] mode, input t_desc rq,
                                                  input logic [3:0] rel);
        pool_answer_t a;
        int k;
        logic [3:0] s;
        a = '{handle: '0, status: ST_DONE, dropped: '0};
        case (mode)
            MODE_ACQUIRE: begin
                a.status = ST_FULL;
                // first matching free slot in release order
                for (k = 0; k < p_free_q.size(); k++) begin
                    s = p_free_q[k];
                    if (p_desc[s] == rq) begin
                        p_free_q.delete(k);
                        p_in_use[s] = 1'b1;
                        a.handle = s;
                        a.status = ST_REUSED;
                        break;
                    end
                end
                if (a.status == ST_FULL) begin
                    for (k = 0; k < NSLOT; k++) begin
                        if (!p_valid[k]) begin
                            p_valid[k] = 1'b1;
                            p_in_use[k] = 1'b1;
                            p_desc[k] = rq;
                            p_idle[k] = '0;
                            a.handle = k[3:0];
                            a.status = ST_CREATED;
                            break;
                        end
                    end
                end
            end
            MODE_RELEASE: begin
                if (p_valid[rel] && p_in_use[rel]) begin
                    p_in_use[rel] = 1'b0;
                    p_idle[rel] = '0;
                    p_free_q.insert(p_free_q.size(), rel);
                end else begin
                    a.status = ST_NOT_FOUND;
                end
            end
            MODE_TICK: begin
                foreach (p_free_q[i]) begin
                    if (p_idle[p_free_q[i]] != IDLE_MAX) p_idle[p_free_q[i]]++;
                end
            end
            MODE_SWEEP: begin
                k = 0;
                while (k < p_free_q.size() && a.dropped < drop_limit_q) begin
                    s = p_free_q[k];
                    if (p_idle[s] >= thresh_q) begin
                        p_valid[s] = 1'b0;
                        p_in_use[s] = 1'b0;
                        p_free_q.delete(k);
                        a.dropped++;
                    end else begin
                        k++;
                    end
                end
            end
            MODE_CLEAR: begin
                for (k = 0; k < NSLOT; k++) begin
                    p_valid[k] = 1'b0;
                    p_in_use[k] = 1'b0;
                end
                p_free_q.delete();
            end
            default: a.status = ST_NOT_FOUND;
        endcase
        return a;
    endfunction

    // result checker: one word per o_done pulse
    always @(posedge i_clk) begin
        pool_answer_t w;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (answers_pending.size() == 0) begin
                report_mismatch("unexpected result word, status", o_status, 0);
            end else begin
                w = answers_pending.pop_front();
                if (o_handle !== w.handle) report_mismatch("handle", o_handle, w.handle);
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                if (o_dropped_count !== w.dropped)
                    report_mismatch("dropped_count", o_dropped_count, w.dropped);
            end
        end
    end

    // hard limit on run length, sized for the longest words plus gaps and pauses
    always @(posedge i_clk) begin
        if (cycle_cnt > 400000) begin
            $display("timeout with %0d results outstanding", answers_pending.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // send one command word, predicting its answer once the pool is idle again
    task automatic send_word(input logic [2:0] mode, input t_desc rq, input logic [3:0] rel);
        while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct)
            @(posedge i_clk);
        start <= 1'b1;
        i_mode <= mode;
        i_req_width <= rq.width;
        i_req_height <= rq.height;
        i_req_format <= rq.format;
        i_req_is_depth <= rq.is_depth;
        i_release_handle <= rel;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        answers_pending.insert(answers_pending.size(), pool_predict(mode, rq, rel));
        words_sent++;
        start <= 1'b0;
        // let start fall before the next word can be sent
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (answers_pending.size() != 0) @(posedge i_clk);
        // an accepted word may still be in flight right after the handshake
        repeat (60) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_IDLE_THRESHOLD) thresh_q = val[15:0];
        else drop_limit_q = val[4:0];
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [4:0] lim);
        wait_drained();
        apb_write(REG_IDLE_THRESHOLD, {16'd0, thr});
        apb_write(REG_MAX_DROPS, {27'd0, lim});
    endtask

    function automatic t_desc mk(input int w, input int h, input int f, input int d);
        t_desc r;
        r.width = w[14:0]; r.height = h[14:0]; r.format = f[7:0]; r.is_depth = d[0];
        return r;
    endfunction

    // small descriptor alphabet so acquires often match free slots
    function automatic t_desc pick_desc();
        if ($urandom_range(9, 0) < 7)
            return mk($urandom_range(3, 0) * 512, $urandom_range(1, 0) * 256 + 16384 - 256,
                      $urandom_range(2, 0), $urandom_range(1, 0));
        return mk($urandom_range(32767, 0), $urandom_range(32767, 0),
                  $urandom_range(255, 0), $urandom_range(1, 0));
    endfunction

    task automatic test_directed();
        t_desc z;
        z = mk(0, 0, 0, 0);
        send_word(MODE_ACQUIRE, mk(16384, 16384, 255, 1), '0);
        send_word(MODE_ACQUIRE, mk(32767, 32767, 255, 1), '0);
        send_word(MODE_ACQUIRE, z, '0);
        send_word(MODE_RELEASE, z, 4'd15);   // unused slot: not found
        send_word(MODE_RELEASE, z, 4'd1);
        send_word(MODE_RELEASE, z, 4'd1);    // already free: not found
        send_word(MODE_ACQUIRE, mk(32767, 32767, 255, 1), '0);  // reuse
        for (int i = 0; i < 14; i++) send_word(MODE_ACQUIRE, mk(i, 1, 2, 0), '0);
        send_word(MODE_ACQUIRE, mk(7, 7, 7, 1), '0);  // pool full
        send_word(3'd5, z, '0);
        send_word(3'd7, z, '0);
        send_word(MODE_RELEASE, z, 4'd0);
        send_word(MODE_TICK, z, '0);
        send_word(MODE_SWEEP, z, '0);
        send_word(MODE_CLEAR, z, '0);
    endtask

    // random well-formed traffic with some noise
    task automatic test_random(input int n, input int idle_pct);
        logic [2:0] m;
        int r;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99, 0);
            if (r < 38) m = MODE_ACQUIRE;
            else if (r < 70) m = MODE_RELEASE;
            else if (r < 84) m = MODE_TICK;
            else if (r < 95) m = MODE_SWEEP;
            else if (r < 97) m = MODE_CLEAR;
            else m = 3'($urandom_range(7, 5));
            send_word(m, pick_desc(), 4'($urandom_range(15, 0)));
            if (i == n / 2) wait_drained();
        end
        sender_idle_pct = 0;
    endtask

    // long idle aging against the highest threshold
    task automatic test_saturation();
        set_config(16'hFFFF, 5'd16);
        send_word(MODE_ACQUIRE, mk(1, 1, 1, 1), '0);
        send_word(MODE_ACQUIRE, mk(2, 2, 2, 0), '0);
        send_word(MODE_RELEASE, mk(0, 0, 0, 0), 4'd0);
        send_word(MODE_RELEASE, mk(0, 0, 0, 0), 4'd1);
        for (int i = 0; i < 120; i++) send_word(MODE_TICK, mk(0, 0, 0, 0), '0);
        send_word(MODE_SWEEP, mk(0, 0, 0, 0), '0);
    endtask

    initial begin
        int k;
        thresh_q = IDLE_THRESHOLD_RST;
        drop_limit_q = MAX_DROPS_RST;
        for (k = 0; k < NSLOT; k++) begin
            p_valid[k] = 1'b0; p_in_use[k] = 1'b0; p_idle[k] = '0; p_desc[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_config(16'd0, 5'd0);
        test_random(300, 13);
        set_config(16'd2, 5'd16);
        test_random(450, 80);
        set_config(16'd5, 5'd3);
        test_random(500, 0);
        set_config(16'd1, 5'd1);
        test_random(450, 13);
        test_saturation();

        wait_drained();
        $display("sent %0d command words, checked %0d result words", words_sent, results_seen);
        $display("covered acquire reuse and create, release misses, aging, sweeps, clears");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
